// ===== design/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Types and constants shared by the step/direction pulser modules.
// ----------------------------------------------------------------------------
package spd_pkg;

   // Number of axes and width of a position counter.
   localparam int AXES     = 4;
   localparam int POS_BITS = 32;

   // Field widths.
   localparam int AXES_W   = 3;
   localparam int TICK_W   = 16;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IW-1:0] CSR_AXES_IN_USE = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_ENABLE_MASK = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_SETUP_TICKS = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_PULSE_TICKS = 2'd3;

   // Register values after reset.
   localparam logic [AXES_W-1:0] RST_AXES_IN_USE = 3'd3;
   localparam logic [AXES-1:0]   RST_ENABLE_MASK = 4'd0;
   localparam logic [TICK_W-1:0] RST_SETUP_TICKS = 16'd50;
   localparam logic [TICK_W-1:0] RST_PULSE_TICKS = 16'd100;

   typedef enum logic {
      OP_STEP = 1'b0,
      OP_LOAD = 1'b1
   } opcode_type;

   // Output phase of a step command.
   typedef enum logic [1:0] {
      PH_SETUP = 2'd0,
      PH_PULSE = 2'd1,
      PH_DONE  = 2'd2
   } phase_type;

   typedef logic [AXES-1:0][POS_BITS-1:0] pos_vec_type;

   // One held command.
   typedef struct packed {
      opcode_type       opcode;
      logic [AXES-1:0]  step;
      logic [AXES-1:0]  dir;
      pos_vec_type      load_pos;
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic [AXES-1:0]   step_lines;
      logic [AXES-1:0]   dir_lines;
      logic [AXES-1:0]   enable_lines_n;
      logic [TICK_W-1:0] hold_ticks;
      logic              last_of_run;
      pos_vec_type       pos;
   } rsp_type;

   // State updates requested by the phase generator.
   typedef struct packed {
      logic             dir_we;
      logic [AXES-1:0]  dir_next;
      logic             pos_we;
      pos_vec_type      pos_next;
      phase_type        phase_next;
   } upd_type;

   // Axis count above AXES acts as AXES.
   function automatic logic [AXES-1:0] used_mask(input logic [AXES_W-1:0] n);
      logic [AXES-1:0] m;
      for (int i = 0; i < AXES; i++) begin
         m[i] = (int'(n) > i);
      end
      return m;
   endfunction

endpackage

// ===== design/spd_axis_update.sv =====
// ----------------------------------------------------------------------------
// spd_axis_update
// Per-axis position counters after one step: +1 or -1 where a step is set.
// ----------------------------------------------------------------------------
module spd_axis_update (
   input  logic [spd_pkg::AXES-1:0] step,
   input  logic [spd_pkg::AXES-1:0] dir,
   input  spd_pkg::pos_vec_type     pos,
   output spd_pkg::pos_vec_type     pos_next
);
   import spd_pkg::*;

   // One incrementer per axis; adding all ones steps down with wrap.
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         if (step[i]) begin
            pos_next[i] = dir[i] ? pos[i] + POS_BITS'(1) : pos[i] + {POS_BITS{1'b1}};
         end else begin
            pos_next[i] = pos[i];
         end
      end
   end

endmodule

// ===== design/spd_phase_gen.sv =====
// ----------------------------------------------------------------------------
// spd_phase_gen
// Builds the result item of the current phase and the state updates it needs.
// ----------------------------------------------------------------------------
module spd_phase_gen (
   input  spd_pkg::cmd_type               cmd,
   input  spd_pkg::phase_type             phase,
   input  logic [spd_pkg::AXES_W-1:0]     axes_in_use,
   input  logic [spd_pkg::AXES-1:0]       enable_mask,
   input  logic [spd_pkg::TICK_W-1:0]     setup_ticks,
   input  logic [spd_pkg::TICK_W-1:0]     pulse_ticks,
   input  logic [spd_pkg::AXES-1:0]       dir_level,
   input  spd_pkg::pos_vec_type           pos,
   output spd_pkg::rsp_type               rsp,
   output spd_pkg::upd_type               upd
);
   import spd_pkg::*;

   logic [AXES-1:0] used;
   logic [AXES-1:0] step_m;
   logic [AXES-1:0] dir_new;
   pos_vec_type     pos_stepped;

   assign used    = used_mask(axes_in_use);
   assign step_m  = cmd.step & used;
   assign dir_new = (dir_level & ~used) | (cmd.dir & used);

   spd_axis_update u_axis_update (
      .step     (step_m),
      .dir      (cmd.dir),
      .pos      (pos),
      .pos_next (pos_stepped)
   );

   // Result fields and state updates per phase.
   always_comb begin
      rsp.step_lines     = '0;
      rsp.dir_lines      = dir_level;
      rsp.enable_lines_n = ~(enable_mask & used);
      rsp.hold_ticks     = '0;
      rsp.last_of_run    = 1'b0;
      rsp.pos            = pos;
      upd.dir_we         = 1'b0;
      upd.dir_next       = dir_new;
      upd.pos_we         = 1'b0;
      upd.pos_next       = pos_stepped;
      upd.phase_next     = PH_SETUP;
      if (cmd.opcode == OP_LOAD) begin
         upd.pos_we      = 1'b1;
         upd.pos_next    = cmd.load_pos;
         rsp.pos         = cmd.load_pos;
         rsp.last_of_run = 1'b1;
      end else begin
         unique case (phase)
            PH_SETUP: begin
               upd.dir_we     = 1'b1;
               rsp.dir_lines  = dir_new;
               rsp.hold_ticks = setup_ticks;
               upd.phase_next = PH_PULSE;
            end
            PH_PULSE: begin
               rsp.step_lines = step_m;
               rsp.hold_ticks = pulse_ticks;
               upd.phase_next = PH_DONE;
            end
            PH_DONE: begin
               upd.pos_we      = 1'b1;
               rsp.pos         = pos_stepped;
               rsp.last_of_run = 1'b1;
            end
            default: begin
               upd.phase_next = PH_SETUP;
            end
         endcase
      end
   end

endmodule

// ===== design/stepper_step_dir_pulser.sv =====
// A command waits in the command register, and its result items pass through the
// output register. A step command yields three items, a load one item; the single
// command register and one result per cycle while rsp_ready is high set this.
// A new command is taken in the cycle its last item moves to the output register.
// Reset (synchronous) clears positions, direction levels, the valid flags and
// loads the register defaults.
// ----------------------------------------------------------------------------
// stepper_step_dir_pulser
// Step/direction pulse generator with per-axis position counters.
// ----------------------------------------------------------------------------
module stepper_step_dir_pulser (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration port.
   input  logic                              csr_write_en,
   input  logic [spd_pkg::CSR_IW-1:0]        csr_index,
   input  logic [spd_pkg::CSR_DW-1:0]        csr_wdata,
   // Command channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [spd_pkg::AXES-1:0]          req_step_bits,
   input  logic [spd_pkg::AXES-1:0]          req_dir_bits,
   input  logic signed [spd_pkg::POS_BITS-1:0] req_load_pos_0,
   input  logic signed [spd_pkg::POS_BITS-1:0] req_load_pos_1,
   input  logic signed [spd_pkg::POS_BITS-1:0] req_load_pos_2,
   input  logic signed [spd_pkg::POS_BITS-1:0] req_load_pos_3,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spd_pkg::AXES-1:0]          rsp_step_lines,
   output logic [spd_pkg::AXES-1:0]          rsp_dir_lines,
   output logic [spd_pkg::AXES-1:0]          rsp_enable_lines_n,
   output logic [spd_pkg::TICK_W-1:0]        rsp_hold_ticks,
   output logic                              rsp_last_of_run,
   output logic signed [spd_pkg::POS_BITS-1:0] rsp_pos_0,
   output logic signed [spd_pkg::POS_BITS-1:0] rsp_pos_1,
   output logic signed [spd_pkg::POS_BITS-1:0] rsp_pos_2,
   output logic signed [spd_pkg::POS_BITS-1:0] rsp_pos_3
);
   import spd_pkg::*;

   logic [AXES_W-1:0] axes_in_use_ff;
   logic [AXES-1:0]   enable_mask_ff;
   logic [TICK_W-1:0] setup_ticks_ff;
   logic [TICK_W-1:0] pulse_ticks_ff;

   logic        cmd_valid_ff, cmd_valid_in;
   cmd_type     cmd_ff, cmd_in;
   phase_type   phase_ff, phase_in;
   logic [AXES-1:0] dir_level_ff;
   pos_vec_type pos_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   rsp_type     gen_rsp;
   upd_type     gen_upd;
   logic        out_adv;
   logic        emit;
   logic        req_fire;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         axes_in_use_ff <= RST_AXES_IN_USE;
         enable_mask_ff <= RST_ENABLE_MASK;
         setup_ticks_ff <= RST_SETUP_TICKS;
         pulse_ticks_ff <= RST_PULSE_TICKS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_AXES_IN_USE: axes_in_use_ff <= csr_wdata[AXES_W-1:0];
            CSR_ENABLE_MASK: enable_mask_ff <= csr_wdata[AXES-1:0];
            CSR_SETUP_TICKS: setup_ticks_ff <= csr_wdata[TICK_W-1:0];
            CSR_PULSE_TICKS: pulse_ticks_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   spd_phase_gen u_phase_gen (
      .cmd         (cmd_ff),
      .phase       (phase_ff),
      .axes_in_use (axes_in_use_ff),
      .enable_mask (enable_mask_ff),
      .setup_ticks (setup_ticks_ff),
      .pulse_ticks (pulse_ticks_ff),
      .dir_level   (dir_level_ff),
      .pos         (pos_ff),
      .rsp         (gen_rsp),
      .upd         (gen_upd)
   );

   // Handshake: the output register takes a new item when empty or drained.
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign emit      = cmd_valid_ff && out_adv;
   assign req_ready = !cmd_valid_ff || (emit && gen_rsp.last_of_run);
   assign req_fire  = req_valid && req_ready;

   // Next command register and phase.
   always_comb begin
      cmd_valid_in = cmd_valid_ff;
      cmd_in       = cmd_ff;
      phase_in     = phase_ff;
      if (emit) begin
         phase_in = gen_upd.phase_next;
         if (gen_rsp.last_of_run) begin
            cmd_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         cmd_valid_in       = 1'b1;
         cmd_in.opcode      = opcode_type'(req_opcode);
         cmd_in.step        = req_step_bits;
         cmd_in.dir         = req_dir_bits;
         cmd_in.load_pos[0] = req_load_pos_0;
         cmd_in.load_pos[1] = req_load_pos_1;
         cmd_in.load_pos[2] = req_load_pos_2;
         cmd_in.load_pos[3] = req_load_pos_3;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         phase_ff     <= PH_SETUP;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Axis state: direction levels and position counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_level_ff <= '0;
         pos_ff       <= '0;
      end else if (emit) begin
         if (gen_upd.dir_we) begin
            dir_level_ff <= gen_upd.dir_next;
         end
         if (gen_upd.pos_we) begin
            pos_ff <= gen_upd.pos_next;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         rsp_ff <= gen_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_lines     = rsp_ff.step_lines;
   assign rsp_dir_lines      = rsp_ff.dir_lines;
   assign rsp_enable_lines_n = rsp_ff.enable_lines_n;
   assign rsp_hold_ticks     = rsp_ff.hold_ticks;
   assign rsp_last_of_run    = rsp_ff.last_of_run;
   assign rsp_pos_0          = rsp_ff.pos[0];
   assign rsp_pos_1          = rsp_ff.pos[1];
   assign rsp_pos_2          = rsp_ff.pos[2];
   assign rsp_pos_3          = rsp_ff.pos[3];

endmodule

// ===== design/spd_checker.sv =====
// ----------------------------------------------------------------------------
// spd_checker
// Port-level checks for the step/direction pulser, bound to the top level.
// ----------------------------------------------------------------------------
module spd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [spd_pkg::AXES-1:0]      rsp_step_lines,
   input logic [spd_pkg::TICK_W-1:0]    rsp_hold_ticks,
   input logic                          rsp_last_of_run
);
   import spd_pkg::*;

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result keeps its step levels and hold time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_lines)
         && $stable(rsp_hold_ticks) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // The last item of a command leaves the step lines low and has a zero hold time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> rsp_step_lines == '0 && rsp_hold_ticks == '0)
      else $error("final item with step lines high or nonzero hold");

   // The phases of a step command follow each other without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a step command");

endmodule

bind stepper_step_dir_pulser spd_checker u_spd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_step_lines  (rsp_step_lines),
   .rsp_hold_ticks  (rsp_hold_ticks),
   .rsp_last_of_run (rsp_last_of_run)
);

// ===== test/spd_checker.sv =====
// ----------------------------------------------------------------------------
// spd_tb_checker
// Watches the register port and both channels of the step/direction pulser.
// It keeps its own copy of the axis positions, direction levels and register
// values, works out the phases that each accepted command must produce, and
// compares every accepted result item field by field with the oldest of them.
// ----------------------------------------------------------------------------
module spd_tb_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [spd_pkg::CSR_IW-1:0]          csr_index,
   input  logic [spd_pkg::CSR_DW-1:0]          csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [spd_pkg::AXES-1:0]            req_step_bits,
   input  logic [spd_pkg::AXES-1:0]            req_dir_bits,
   input  logic [spd_pkg::POS_BITS-1:0]        req_load_pos_0,
   input  logic [spd_pkg::POS_BITS-1:0]        req_load_pos_1,
   input  logic [spd_pkg::POS_BITS-1:0]        req_load_pos_2,
   input  logic [spd_pkg::POS_BITS-1:0]        req_load_pos_3,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [spd_pkg::AXES-1:0]            rsp_step_lines,
   input  logic [spd_pkg::AXES-1:0]            rsp_dir_lines,
   input  logic [spd_pkg::AXES-1:0]            rsp_enable_lines_n,
   input  logic [spd_pkg::TICK_W-1:0]          rsp_hold_ticks,
   input  logic                                rsp_last_of_run,
   input  logic [spd_pkg::POS_BITS-1:0]        rsp_pos_0,
   input  logic [spd_pkg::POS_BITS-1:0]        rsp_pos_1,
   input  logic [spd_pkg::POS_BITS-1:0]        rsp_pos_2,
   input  logic [spd_pkg::POS_BITS-1:0]        rsp_pos_3,
   output int                                  mismatch_count,
   output int                                  pending_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import spd_pkg::*;

   // Shadow of the block's state and registers.
   pos_vec_type         axis_pos    = '0;
   logic [AXES-1:0]     dir_held    = '0;
   logic [AXES_W-1:0]   cfg_axes    = RST_AXES_IN_USE;
   logic [AXES-1:0]     cfg_enable  = RST_ENABLE_MASK;
   logic [TICK_W-1:0]   cfg_setup   = RST_SETUP_TICKS;
   logic [TICK_W-1:0]   cfg_pulse   = RST_PULSE_TICKS;

   rsp_type             expected_phases[$];
   int                  errors      = 0;

   // Axes below the configured count; a count above AXES drives all of them.
   function automatic logic [AXES-1:0] driven_axes();
      logic [AXES-1:0] m;
      m = '0;
      for (int i = 0; i < AXES; i++) begin
         if (i < int'(cfg_axes)) m[i] = 1'b1;
      end
      return m;
   endfunction

   // One result item as the lines and counters stand right now.
   function automatic rsp_type make_phase(logic [AXES-1:0] step, logic [TICK_W-1:0] hold,
                                          logic last);
      rsp_type r;
      r.step_lines     = step;
      r.dir_lines      = dir_held;
      r.enable_lines_n = ~(cfg_enable & driven_axes());
      r.hold_ticks     = hold;
      r.last_of_run    = last;
      r.pos            = axis_pos;
      return r;
   endfunction

   // Appends one expected item at the tail of the queue.
   task automatic add_expected(rsp_type r);
      expected_phases = {expected_phases, r};
   endtask

   // Expected phases of one command, and its effect on the shadow state.
   task automatic predict_command(opcode_type op, logic [AXES-1:0] step,
                                  logic [AXES-1:0] dir, pos_vec_type load);
      logic [AXES-1:0] used;
      logic [AXES-1:0] moving;
      used = driven_axes();
      if (op == OP_LOAD) begin
         axis_pos = load;
         add_expected(make_phase('0, '0, 1'b1));
      end else begin
         moving   = step & used;
         dir_held = (dir_held & ~used) | (dir & used);
         add_expected(make_phase('0, cfg_setup, 1'b0));
         add_expected(make_phase(moving, cfg_pulse, 1'b0));
         for (int i = 0; i < AXES; i++) begin
            if (moving[i]) begin
               axis_pos[i] = dir[i] ? axis_pos[i] + POS_BITS'(1)
                                    : axis_pos[i] - POS_BITS'(1);
            end
         end
         add_expected(make_phase('0, '0, 1'b1));
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // All sampling happens on the values that stand before the clock edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         axis_pos   = '0;
         dir_held   = '0;
         cfg_axes   = RST_AXES_IN_USE;
         cfg_enable = RST_ENABLE_MASK;
         cfg_setup  = RST_SETUP_TICKS;
         cfg_pulse  = RST_PULSE_TICKS;
         expected_phases.delete();
      end else begin
         // Register writes.
         if (csr_write_en) begin
            case (csr_index)
               CSR_AXES_IN_USE: cfg_axes   = csr_wdata[AXES_W-1:0];
               CSR_ENABLE_MASK: cfg_enable = csr_wdata[AXES-1:0];
               CSR_SETUP_TICKS: cfg_setup  = csr_wdata[TICK_W-1:0];
               CSR_PULSE_TICKS: cfg_pulse  = csr_wdata[TICK_W-1:0];
               default: ;
            endcase
         end

         // Accepted command item.
         if (req_valid && req_ready) begin
            predict_command(opcode_type'(req_opcode), req_step_bits, req_dir_bits,
                            {req_load_pos_3, req_load_pos_2, req_load_pos_1, req_load_pos_0});
         end

         // Accepted result item.
         if (rsp_valid && rsp_ready) begin
            if (expected_phases.size() == 0) begin
               errors++;
               $display("%0t: result item with nothing expected, expected none, actual %h",
                        $time, {rsp_step_lines, rsp_dir_lines, rsp_hold_ticks});
            end else begin
               want = expected_phases.pop_front();
               check_field("step_lines", 32'(want.step_lines), 32'(rsp_step_lines));
               check_field("dir_lines", 32'(want.dir_lines), 32'(rsp_dir_lines));
               check_field("enable_lines_n", 32'(want.enable_lines_n),
                           32'(rsp_enable_lines_n));
               check_field("hold_ticks", 32'(want.hold_ticks), 32'(rsp_hold_ticks));
               check_field("last_of_run", 32'(want.last_of_run), 32'(rsp_last_of_run));
               check_field("pos_0", want.pos[0], rsp_pos_0);
               check_field("pos_1", want.pos[1], rsp_pos_1);
               check_field("pos_2", want.pos[2], rsp_pos_2);
               check_field("pos_3", want.pos[3], rsp_pos_3);
            end
         end
      end
      mismatch_count  <= errors;
      pending_results <= expected_phases.size();
   end

endmodule

// ===== test/stepper_step_dir_pulser_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_step_dir_pulser_tb
// Drives step and load commands into the pulser under several register
// settings: a directed set covering line masks, axis counts and position wrap,
// then random commands in bursts while the result side stalls on its own
// pattern. The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module stepper_step_dir_pulser_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spd_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 160;
   localparam int RANDOM_PHASES = 5;
   localparam int LONG_HOLD     = 200;

   // Result-side stall patterns.
   typedef enum int {
      RX_STREAM,
      RX_COIN,
      RX_SPARSE,
      RX_BURSTY
   } rx_mode_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IW-1:0]     csr_index      = '0;
   logic [CSR_DW-1:0]     csr_wdata      = '0;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic                  req_opcode     = OP_STEP;
   logic [AXES-1:0]       req_step_bits  = '0;
   logic [AXES-1:0]       req_dir_bits   = '0;
   logic [POS_BITS-1:0]   req_load_pos_0 = '0;
   logic [POS_BITS-1:0]   req_load_pos_1 = '0;
   logic [POS_BITS-1:0]   req_load_pos_2 = '0;
   logic [POS_BITS-1:0]   req_load_pos_3 = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [AXES-1:0]       rsp_step_lines;
   logic [AXES-1:0]       rsp_dir_lines;
   logic [AXES-1:0]       rsp_enable_lines_n;
   logic [TICK_W-1:0]     rsp_hold_ticks;
   logic                  rsp_last_of_run;
   logic [POS_BITS-1:0]   rsp_pos_0;
   logic [POS_BITS-1:0]   rsp_pos_1;
   logic [POS_BITS-1:0]   rsp_pos_2;
   logic [POS_BITS-1:0]   rsp_pos_3;

   int                    mismatch_count;
   int                    pending_results;
   int                    cycle_count    = 0;
   int                    hold_off_asks  = 0;
   int                    burst_left     = 4;

   stepper_step_dir_pulser dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_step_bits(req_step_bits), .req_dir_bits(req_dir_bits),
      .req_load_pos_0(req_load_pos_0), .req_load_pos_1(req_load_pos_1),
      .req_load_pos_2(req_load_pos_2), .req_load_pos_3(req_load_pos_3),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_step_lines(rsp_step_lines),
      .rsp_dir_lines(rsp_dir_lines), .rsp_enable_lines_n(rsp_enable_lines_n),
      .rsp_hold_ticks(rsp_hold_ticks), .rsp_last_of_run(rsp_last_of_run),
      .rsp_pos_0(rsp_pos_0), .rsp_pos_1(rsp_pos_1), .rsp_pos_2(rsp_pos_2),
      .rsp_pos_3(rsp_pos_3)
   );

   spd_tb_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_step_bits(req_step_bits), .req_dir_bits(req_dir_bits),
      .req_load_pos_0(req_load_pos_0), .req_load_pos_1(req_load_pos_1),
      .req_load_pos_2(req_load_pos_2), .req_load_pos_3(req_load_pos_3),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_step_lines(rsp_step_lines),
      .rsp_dir_lines(rsp_dir_lines), .rsp_enable_lines_n(rsp_enable_lines_n),
      .rsp_hold_ticks(rsp_hold_ticks), .rsp_last_of_run(rsp_last_of_run),
      .rsp_pos_0(rsp_pos_0), .rsp_pos_1(rsp_pos_1), .rsp_pos_2(rsp_pos_2),
      .rsp_pos_3(rsp_pos_3),
      .mismatch_count(mismatch_count), .pending_results(pending_results)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: switches among randomly chosen stall patterns, and holds off
   // for a long stretch whenever the stimulus asks for it.
   initial begin
      rx_mode_type mode;
      int          mode_cycles;
      int          stall_left;
      int          hold_left;
      int          hold_off_seen;
      mode          = RX_STREAM;
      mode_cycles   = 0;
      stall_left    = 0;
      hold_left     = 0;
      hold_off_seen = 0;
      forever begin
         @(posedge clock);
         mode_cycles++;
         if (hold_off_asks != hold_off_seen) begin
            hold_off_seen = hold_off_asks;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_cycles >= 50) begin
               mode        = rx_mode_type'($urandom_range(0, 3));
               mode_cycles = 0;
            end
            case (mode)
               RX_STREAM: rsp_ready <= 1'b1;
               RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready <= (mode_cycles % 4 == 0);
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_ready <= 1'b0;
                  end else if ($urandom_range(0, 5) == 0) begin
                     stall_left = $urandom_range(1, 15);
                     rsp_ready <= 1'b0;
                  end else begin
                     rsp_ready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Offers one command item and waits until it is accepted. Valid stays high
   // into the next item unless the burst has run out.
   task automatic send_item(opcode_type op, logic [AXES-1:0] step, logic [AXES-1:0] dir,
                            logic [31:0] p0, logic [31:0] p1, logic [31:0] p2,
                            logic [31:0] p3);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_step_bits  <= step;
      req_dir_bits   <= dir;
      req_load_pos_0 <= p0;
      req_load_pos_1 <= p1;
      req_load_pos_2 <= p2;
      req_load_pos_3 <= p3;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
   endtask

   // Stops offering and waits until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (2) @(posedge clock);
   endtask

   // Writes all four registers on consecutive cycles; call only while idle.
   task automatic set_config(int axes, int enable, int setup, int pulse);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_AXES_IN_USE;
      csr_wdata    <= CSR_DW'(axes);
      @(posedge clock);
      csr_index    <= CSR_ENABLE_MASK;
      csr_wdata    <= CSR_DW'(enable);
      @(posedge clock);
      csr_index    <= CSR_SETUP_TICKS;
      csr_wdata    <= CSR_DW'(setup);
      @(posedge clock);
      csr_index    <= CSR_PULSE_TICKS;
      csr_wdata    <= CSR_DW'(pulse);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Positions favor the values around the two's complement wrap.
   function automatic logic [31:0] pick_pos();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         4:       return 32'h7FFF_FFFE;
         5:       return 32'h8000_0001;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_ticks();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 16'hFFFF;
         2:       return $urandom_range(1, 8);
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   task automatic random_item();
      if ($urandom_range(0, 4) == 0) begin
         send_item(OP_LOAD, 4'($urandom), 4'($urandom),
                   pick_pos(), pick_pos(), pick_pos(), pick_pos());
      end else begin
         send_item(OP_STEP, 4'($urandom), 4'($urandom),
                   $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   // Stimulus and verdict.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: three axes, the fourth must stay untouched.
      send_item(OP_STEP, 4'hF, 4'hF, 0, 0, 0, 0);
      send_item(OP_STEP, 4'hF, 4'h0, 0, 0, 0, 0);
      send_item(OP_STEP, 4'h0, 4'hA, 0, 0, 0, 0);
      send_item(OP_LOAD, 4'h0, 4'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF);
      send_item(OP_STEP, 4'hF, 4'hF, 0, 0, 0, 0);
      send_item(OP_LOAD, 4'hF, 4'hF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000);
      send_item(OP_STEP, 4'hF, 4'h0, 0, 0, 0, 0);

      // All axes enabled, shortest setup and longest pulse.
      drain();
      set_config(4, 4'hF, 0, 16'hFFFF);
      send_item(OP_LOAD, 4'h0, 4'h0, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h8000_0000);
      send_item(OP_STEP, 4'hF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      send_item(OP_STEP, 4'h5, 4'hA, 0, 0, 0, 0);
      send_item(OP_STEP, 4'hA, 4'h5, 0, 0, 0, 0);

      // No axis in use: nothing moves and the direction levels hold.
      drain();
      set_config(0, 4'hF, 16'hFFFF, 0);
      send_item(OP_STEP, 4'hF, 4'hF, 0, 0, 0, 0);
      send_item(OP_LOAD, 4'h0, 4'h0, $urandom, $urandom, $urandom, $urandom);

      // Axis count above the axes present acts as all of them.
      drain();
      set_config(7, 4'hA, 1, 1);
      send_item(OP_STEP, 4'hF, 4'h0, 0, 0, 0, 0);
      send_item(OP_STEP, 4'hF, 4'hF, 0, 0, 0, 0);

      // A single axis in use.
      drain();
      set_config(1, 4'h5, 16'h8000, 16'h7FFF);
      send_item(OP_STEP, 4'hF, 4'hF, 0, 0, 0, 0);
      send_item(OP_STEP, 4'h1, 4'h0, 0, 0, 0, 0);

      // Random commands under a fresh register setting per phase.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         set_config($urandom_range(0, 7), $urandom_range(0, 15), pick_ticks(), pick_ticks());
         // Long result-side hold-off while the sender keeps offering.
         if (phase == 1) hold_off_asks <= hold_off_asks + 1;
         for (int k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++) begin
            random_item();
            if (phase == 3 && k == 16) drain();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== stepper_step_dir_pulser.f =====
design/spd_pkg.sv
design/spd_axis_update.sv
design/spd_phase_gen.sv
design/stepper_step_dir_pulser.sv
design/spd_checker.sv
test/spd_checker.sv
test/stepper_step_dir_pulser_tb.sv
